// ===== design/assert_macros.svh =====
// Assertion macros shared by the design files.
// Each macro wraps a clocked, reset-qualified concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of i_clk, disabled while reset is low.
`define SPL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SPL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/spl_pkg.sv =====
// Shared types and constants of the sorted priority list.
// No dependencies; used by spl_cell and sorted_priority_list.
package spl_pkg;

    localparam int KEY_W   = 20;
    localparam int SCORE_W = 32;
    localparam int CNT_W   = 5;

    // Operation codes carried in the input tuser field.
    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_QUERY  = 2'd2
    } t_kind;

    // One stored entry.
    typedef struct packed {
        logic        [KEY_W-1:0]   key;
        logic signed [SCORE_W-1:0] score;
    } t_entry;

    // Per-transaction strobes broadcast to every cell.
    typedef struct packed {
        logic acc;  // a transaction is accepted this cycle
        logic ins;  // insert into a list that is not full
        logic rem;  // remove from a list that is not empty
    } t_cell_ctl;

endpackage

// ===== design/spl_cell.sv =====
// One slot of the sorted list: holds an entry and trades it with its neighbors.
// Depends on spl_pkg.
module spl_cell
    import spl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_new,
    input  logic      i_prev_valid,
    input  t_entry    i_prev_entry,
    input  logic      i_prev_hit,
    input  logic      i_next_valid,
    input  t_entry    i_next_entry,
    output logic      o_valid,
    output t_entry    o_entry,
    output logic      o_hit,
    output logic      o_match
);

    logic   r_valid;
    t_entry r_entry;
    logic   r_match;

    // The new entry belongs at or ahead of this slot when the slot is empty
    // or holds a score greater than or equal to the new one.
    assign o_hit = !r_valid || ($signed(i_new.score) <= $signed(r_entry.score));

    // Valid bit: shift down on insert, shift up on remove.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.ins) begin
            if (i_prev_hit) begin
                r_valid <= i_prev_valid;
            end else if (o_hit) begin
                r_valid <= 1'b1;
            end
        end else if (i_ctl.rem) begin
            r_valid <= i_next_valid;
        end
    end

    // Entry payload follows the same moves as the valid bit.
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            if (i_prev_hit) begin
                r_entry <= i_prev_entry;
            end else if (o_hit) begin
                r_entry <= i_new;
            end
        end else if (i_ctl.rem) begin
            r_entry <= i_next_entry;
        end
    end

    // Key match against the contents seen by the accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctl.acc) begin
            r_match <= r_valid && (r_entry.key == i_new.key);
        end
    end

    assign o_valid = r_valid;
    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule

// ===== design/sorted_priority_list.sv =====
// Channel   | Dir | Payload
// s_axis    | in  | tuser[1:0] kind; tdata key[19:0], score[51:20]
// m_axis    | out | tdata ok[0], found[1], out_key[21:2], out_score[53:22],
//           |     |       entry_count[58:54]
//
// One transaction is taken every cycle unless o_s_axis_tready drops on an m_axis stall; each result
// is registered in the first result stage (cell row update and key match) and then in the
// output register (key-match OR), where it stays valid on m_axis until it is taken.
// All slots act in parallel, so the rate does not depend on DEPTH.
// Reset (i_rst_n low, synchronous) empties the list and both result stages.
// A stall on m_axis holds the two result stages and drops o_s_axis_tready once the
// first result stage is also full.
//
// Top level of the sorted priority list; depends on spl_pkg, spl_cell and
// assert_macros.svh.
`include "assert_macros.svh"

module sorted_priority_list
    import spl_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [55:0] i_s_axis_tdata,   // key[19:0], score[51:20], zero pad
    input  logic [1:0]  i_s_axis_tuser,   // kind[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata    // ok, found, out_key, out_score,
                                          // entry_count, zero pad
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [DEPTH-1:0] w_valid;
    logic [DEPTH-1:0] w_hit;
    logic [DEPTH-1:0] w_match;
    t_entry           w_entry [DEPTH];

    t_entry    w_new;
    t_kind     w_kind;
    t_cell_ctl w_ctl;
    logic      w_acc;
    logic      w_full;
    logic      w_empty;
    logic      w_p_move;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    logic               r_p_valid;
    t_kind              r_p_kind;
    logic               r_p_ok;
    t_entry             r_p_head;
    logic [CW-1:0]      r_p_count;
    logic               n_p_ok;
    t_entry             n_p_head;

    logic               r_o_valid;
    logic [63:0]        r_o_data;

    logic [CW+CNT_W-1:0] w_cnt_ext;

    // Input unpacking and handshake.
    assign w_new.key   = i_s_axis_tdata[KEY_W-1:0];
    assign w_new.score = i_s_axis_tdata[KEY_W+SCORE_W-1:KEY_W];
    assign w_kind      = t_kind'(i_s_axis_tuser);

    assign w_p_move        = !r_o_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_p_valid || w_p_move;
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;

    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);

    assign w_ctl.acc = w_acc;
    assign w_ctl.ins = w_acc && (w_kind == KIND_INSERT) && !w_full;
    assign w_ctl.rem = w_acc && (w_kind == KIND_REMOVE) && !w_empty;

    // Row of cells; slot 0 holds the smallest score.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic   w_pv;
        t_entry w_pe;
        logic   w_ph;
        logic   w_nv;
        t_entry w_ne;

        if (i == 0) begin : g_first
            assign w_pv = 1'b0;
            assign w_pe = w_new;
            assign w_ph = 1'b0;
        end else begin : g_mid
            assign w_pv = w_valid[i-1];
            assign w_pe = w_entry[i-1];
            assign w_ph = w_hit[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign w_nv = 1'b0;
            assign w_ne = w_new;
        end else begin : g_inner
            assign w_nv = w_valid[i+1];
            assign w_ne = w_entry[i+1];
        end

        spl_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_new        (w_new),
            .i_prev_valid (w_pv),
            .i_prev_entry (w_pe),
            .i_prev_hit   (w_ph),
            .i_next_valid (w_nv),
            .i_next_entry (w_ne),
            .o_valid      (w_valid[i]),
            .o_entry      (w_entry[i]),
            .o_hit        (w_hit[i]),
            .o_match      (w_match[i])
        );
    end

    // Count update and first-stage result fields.
    always_comb begin
        n_count  = r_count;
        n_p_ok   = 1'b0;
        n_p_head = '0;
        unique case (w_kind)
            KIND_INSERT: begin
                if (!w_full) begin
                    n_count = r_count + CW'(1);
                    n_p_ok  = 1'b1;
                end
            end
            KIND_REMOVE: begin
                if (!w_empty) begin
                    n_count  = r_count - CW'(1);
                    n_p_ok   = 1'b1;
                    n_p_head = w_entry[0];
                end
            end
            KIND_QUERY: begin
                n_p_ok = 1'b0;
            end
            default: begin
                n_p_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_acc) begin
            r_count <= n_count;
        end
    end

    // First result stage: waits for the registered key matches.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_acc) begin
            r_p_valid <= 1'b1;
        end else if (w_p_move) begin
            r_p_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_p_kind  <= w_kind;
            r_p_ok    <= n_p_ok;
            r_p_head  <= n_p_head;
            r_p_count <= n_count;
        end
    end

    assign w_cnt_ext = {{CNT_W{1'b0}}, r_p_count};

    // Output register: folds the match vector and packs the transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_p_move) begin
            r_o_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_p_move && r_p_valid) begin
            r_o_data <= {5'b0,
                         w_cnt_ext[CNT_W-1:0],
                         r_p_head.score,
                         r_p_head.key,
                         (r_p_kind == KIND_QUERY) && (|w_match),
                         r_p_ok};
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;

    // Checks on the cell row and the count.
    `SPL_ASSERT(a_count_bound, r_count <= CW'(DEPTH), "stored count exceeds DEPTH")
    `SPL_ASSERT(a_valid_count, $countones(w_valid) == int'(r_count),
                "valid cells disagree with stored count")
    `SPL_ASSERT(a_valid_packed, (w_valid & (w_valid + DEPTH'(1))) == '0,
                "valid cells are not a contiguous run from the head")
    `SPL_ASSERT_NEXT(a_hold_on_stall, r_p_valid && !w_p_move, $stable(r_count),
                     "list changed while the result stage was stalled")

    for (genvar j = 1; j < DEPTH; j++) begin : g_chk
        `SPL_ASSERT(a_sorted,
                    w_valid[j] |-> ($signed(w_entry[j-1].score) <=
                                    $signed(w_entry[j].score)),
                    "cell scores out of ascending order")
    end

endmodule

// ===== bench/tb_sorted_priority_list.sv =====
// Self-checking testbench for sorted_priority_list: directed and random insert,
// remove and contains traffic with random idling and back-pressure on both streams.
// Depends on spl_pkg and the sorted_priority_list RTL.
`timescale 1ns / 100ps

module tb_sorted_priority_list;
    import spl_pkg::*;

    localparam int DEPTH = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [1:0] KIND_NOP = 2'd3;  // unused kind, no operation
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = 32'sh8000_0000;
    localparam logic signed [SCORE_W-1:0] SCORE_MAX = 32'sh7FFF_FFFF;
    localparam logic [KEY_W-1:0] KEY_MAX = 20'hFFFFF;

    // Expected fields of one result transaction.
    typedef struct packed {
        logic                      ok;
        logic                      found;
        logic        [KEY_W-1:0]   key;
        logic signed [SCORE_W-1:0] score;
        logic        [CNT_W-1:0]   count;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [55:0] i_s_axis_tdata = '0;   // key[19:0], score[51:20], zero pad
    logic [1:0]  i_s_axis_tuser = '0;   // kind[1:0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [63:0] o_m_axis_tdata;        // ok, found, out_key, out_score, entry_count

    // Shadow copy of the list contents, head at index 0.
    logic        [KEY_W-1:0]   list_keys [DEPTH];
    logic signed [SCORE_W-1:0] list_scores [DEPTH];
    int                        shadow_count;

    t_result pending_results[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int n_errors = 0;
    int n_checked = 0;
    int n_sent = 0;
    int n_full_rejects = 0;
    int n_empty_removes = 0;
    int n_query_hits = 0;
    int n_ties = 0;
    int stall_cycles = 0;

    sorted_priority_list #(
        .DEPTH(DEPTH)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Clock generation.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Applies one operation to the shadow list and returns the result it should give.
    function automatic t_result predict_op(input logic [1:0] kind,
                                           input logic [KEY_W-1:0] key,
                                           input logic signed [SCORE_W-1:0] score);
        t_result res;
        int      pos;
        res = '0;
        case (kind)
            KIND_INSERT: begin
                if (shadow_count < DEPTH) begin
                    pos = shadow_count;
                    for (int i = 0; i < shadow_count; i++) begin
                        if (score <= list_scores[i]) begin
                            pos = i;
                            if (score == list_scores[i]) n_ties++;
                            break;
                        end
                    end
                    for (int i = shadow_count; i > pos; i--) begin
                        list_keys[i] = list_keys[i-1];
                        list_scores[i] = list_scores[i-1];
                    end
                    list_keys[pos] = key;
                    list_scores[pos] = score;
                    shadow_count++;
                    res.ok = 1'b1;
                end else begin
                    n_full_rejects++;
                end
            end
            KIND_REMOVE: begin
                if (shadow_count > 0) begin
                    res.key = list_keys[0];
                    res.score = list_scores[0];
                    for (int i = 1; i < shadow_count; i++) begin
                        list_keys[i-1] = list_keys[i];
                        list_scores[i-1] = list_scores[i];
                    end
                    shadow_count--;
                    res.ok = 1'b1;
                end else begin
                    n_empty_removes++;
                end
            end
            KIND_QUERY: begin
                for (int i = 0; i < shadow_count; i++) begin
                    if (list_keys[i] == key) begin
                        res.found = 1'b1;
                        n_query_hits++;
                        break;
                    end
                end
            end
            default: begin
            end
        endcase
        res.count = CNT_W'(shadow_count);
        return res;
    endfunction

    // Offers one input transaction, records its expected result once accepted,
    // then idles the sender at random.
    task automatic send_op(input logic [1:0] kind, input logic [KEY_W-1:0] key,
                           input logic signed [SCORE_W-1:0] score);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {4'b0, score, key};
        i_s_axis_tuser <= kind;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_results.push_back(predict_op(kind, key, score));
        n_sent++;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    function automatic logic signed [SCORE_W-1:0] pick_score();
        int offset;
        logic signed [SCORE_W-1:0] s;
        case ($urandom_range(4))
            0: s = $urandom;
            1: begin
                offset = $urandom_range(0, 8);
                s = offset - 4;
            end
            2: begin
                case ($urandom_range(3))
                    0: s = SCORE_MIN;
                    1: s = SCORE_MAX;
                    2: s = '0;
                    default: s = '1;
                endcase
            end
            default: begin
                offset = $urandom_range(0, 200);
                s = offset - 100;
            end
        endcase
        return s;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(1)) return KEY_W'($urandom_range(0, 15));
        return KEY_W'($urandom_range(0, KEY_MAX));
    endfunction

    // One random operation; ins_weight is the insert share in percent.
    task automatic send_random_op(input int ins_weight);
        int r;
        int rem_weight;
        logic [KEY_W-1:0] key;
        r = $urandom_range(99);
        rem_weight = (95 - ins_weight) * 2 / 3;
        key = pick_key();
        if (r < 5) begin
            send_op(KIND_NOP, key, pick_score());
        end else if (r < 5 + ins_weight) begin
            send_op(KIND_INSERT, key, pick_score());
        end else if (r < 5 + ins_weight + rem_weight) begin
            send_op(KIND_REMOVE, key, pick_score());
        end else begin
            // Most queries look for a key that is stored right now.
            if (shadow_count > 0 && $urandom_range(99) < 60)
                key = list_keys[$urandom_range(0, shadow_count - 1)];
            send_op(KIND_QUERY, key, pick_score());
        end
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // Empty-list cases, extreme keys and scores, ties, queries and the unused kind.
    task automatic test_directed();
        send_op(KIND_REMOVE, '0, '0);
        send_op(KIND_QUERY, '0, '0);
        send_op(KIND_NOP, KEY_MAX, SCORE_MAX);
        send_op(KIND_INSERT, '0, SCORE_MIN);
        send_op(KIND_INSERT, KEY_MAX, SCORE_MAX);
        send_op(KIND_INSERT, 20'h55555, SCORE_MAX);
        send_op(KIND_INSERT, 20'h00005, '0);
        send_op(KIND_INSERT, 20'h00006, '0);
        send_op(KIND_INSERT, 20'hAAAAA, -32'sd1);
        send_op(KIND_QUERY, KEY_MAX, '0);
        send_op(KIND_QUERY, 20'h12345, '0);
        send_op(KIND_QUERY, '0, SCORE_MIN);
        send_op(KIND_NOP, '0, '0);
        for (int i = 0; i < 7; i++) send_op(KIND_REMOVE, '0, '0);
        send_op(KIND_QUERY, '0, '0);
        send_op(KIND_INSERT, 20'h00001, SCORE_MIN);
        send_op(KIND_REMOVE, KEY_MAX, SCORE_MAX);
        wait_drained();
    endtask

    // Fills the list past its capacity, then drains it past empty.
    task automatic test_fill_drain();
        for (int i = 0; i < DEPTH + 3; i++) begin
            send_op(KIND_INSERT, pick_key(), pick_score());
            if ($urandom_range(3) == 0) send_op(KIND_QUERY, pick_key(), '0);
        end
        for (int i = 0; i < DEPTH + 3; i++) send_op(KIND_REMOVE, '0, '0);
        wait_drained();
    endtask

    // Random mix in bursts that lean toward filling or toward draining.
    task automatic test_random_mix(input int n_ops);
        int ins_weight;
        ins_weight = 40;
        for (int i = 0; i < n_ops; i++) begin
            if (i % 32 == 0) begin
                case ($urandom_range(2))
                    0: ins_weight = 25;
                    1: ins_weight = 40;
                    default: ins_weight = 60;
                endcase
            end
            send_random_op(ins_weight);
        end
        wait_drained();
    endtask

    // The receiver stalls for a long stretch while the sender keeps offering.
    task automatic test_backpressure();
        hold_request = 60;
        for (int i = 0; i < 40; i++) send_random_op(50);
        wait_drained();
    endtask

    // Receiver ready: long hold-offs on request, otherwise random idling.
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            i_m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        n_errors++;
        $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    endtask

    // Compares each result transaction with the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", o_m_axis_tdata, 0);
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (o_m_axis_tdata[0] !== want.ok)
                    report_mismatch("ok", o_m_axis_tdata[0], want.ok);
                if (o_m_axis_tdata[1] !== want.found)
                    report_mismatch("found", o_m_axis_tdata[1], want.found);
                if (o_m_axis_tdata[21:2] !== want.key)
                    report_mismatch("out_key", o_m_axis_tdata[21:2], want.key);
                if (o_m_axis_tdata[53:22] !== want.score)
                    report_mismatch("out_score", o_m_axis_tdata[53:22], want.score);
                if (o_m_axis_tdata[58:54] !== want.count)
                    report_mismatch("entry_count", o_m_axis_tdata[58:54], want.count);
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    initial begin
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("tb_sorted_priority_list: errors");
        $finish;
    end

    // Test sequence.
    initial begin
        shadow_count = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_idling(30, 47);
        test_directed();
        test_random_mix(430);
        test_fill_drain();

        set_idling(47, 30);
        test_random_mix(430);
        test_fill_drain();

        set_idling(0, 0);
        test_backpressure();
        test_random_mix(430);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("results left over", pending_results.size(), 0);

        $display("Ran %0d operations, %0d results checked, %0d tied scores.",
                 n_sent, n_checked, n_ties);
        $display("Full-list inserts %0d, empty-list removes %0d, query hits %0d.",
                 n_full_rejects, n_empty_removes, n_query_hits);
        if (n_errors == 0) begin
            $display("tb_sorted_priority_list: clean");
        end else begin
            $display("tb_sorted_priority_list: errors");
        end
        $finish;
    end

endmodule

// ===== sorted_priority_list.f =====
+incdir+design
design/spl_pkg.sv
design/spl_cell.sv
design/sorted_priority_list.sv
bench/tb_sorted_priority_list.sv
